// ===== sv/gss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the gear decode function for the gear shift sequencer.
// Used by gss_step and gearshift_sequencer; depends on nothing else.

package gss_pkg;

	localparam int unsigned CFG_W = 16;

	typedef enum logic [2:0] {
		REG_PULSE_MID      = 3'd0,
		REG_PULSE_UP       = 3'd1,
		REG_PULSE_DOWN     = 3'd2,
		REG_PULSE_NEUTRAL  = 3'd3,
		REG_DEAD_TIME      = 3'd4,
		REG_HOLD_SHORT     = 3'd5,
		REG_HOLD_LONG      = 3'd6,
		REG_SETTLE_LOCK    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_DOWN    = 3'd1,
		PH_UP      = 3'd2,
		PH_NEUTRAL = 3'd3,
		PH_HOLD    = 3'd4,
		PH_RETURN  = 3'd5
	} phase_t;

	localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
	localparam logic [2:0] GEAR_FIRST   = 3'd1;
	localparam logic [2:0] GEAR_TOP     = 3'd6;
	localparam logic [2:0] GEAR_INVALID = 3'd7;

	// upper ADC limit of gears one to five, then the lower ADC limit of top gear
	localparam logic [7:0] GEAR_WIN [6] = '{8'd91, 8'd133, 8'd166, 8'd194, 8'd220, 8'd233};
	localparam logic [8:0] TOP_SPAN = 9'd10;

	localparam logic [CFG_W-1:0] RST_PULSE_MID     = 16'd3100;
	localparam logic [CFG_W-1:0] RST_PULSE_UP      = 16'd1707;
	localparam logic [CFG_W-1:0] RST_PULSE_DOWN    = 16'd4292;
	localparam logic [CFG_W-1:0] RST_PULSE_NEUTRAL = 16'd2538;
	localparam logic [CFG_W-1:0] RST_DEAD_TIME     = 16'd500;
	localparam logic [CFG_W-1:0] RST_HOLD_SHORT    = 16'd200;
	localparam logic [CFG_W-1:0] RST_HOLD_LONG     = 16'd300;
	localparam logic [CFG_W-1:0] RST_SETTLE_LOCK   = 16'd180;

	typedef struct packed {
		logic [CFG_W-1:0] pulse_mid;
		logic [CFG_W-1:0] pulse_up;
		logic [CFG_W-1:0] pulse_down;
		logic [CFG_W-1:0] pulse_neutral;
		logic [CFG_W-1:0] dead_time_ms;
		logic [CFG_W-1:0] hold_short_ms;
		logic [CFG_W-1:0] hold_long_ms;
		logic [CFG_W-1:0] settle_lock_ms;
	} cfg_t;

	typedef struct packed {
		logic [15:0] since_move_ms;
		logic [15:0] settle_lock;
		logic        busy_flag;
		phase_t      seq_phase;
		logic        long_hold;
		logic [15:0] pulse_reg;
	} state_t;

	// input beat, lowest field in the lowest bits
	typedef struct packed {
		logic [4:0] pad;
		logic [7:0] gear_sample;
		logic       neutral_switch;
		logic       down_request;
		logic       up_request;
		logic [7:0] elapsed_ms;
	} item_t;

	// result beat, lowest field in the lowest bits
	typedef struct packed {
		logic [2:0]  phase;
		logic        shift_busy;
		logic        servo_enable;
		logic [15:0] servo_pulse;
		logic [2:0]  gear_now;
	} result_t;

	function automatic logic [2:0] decode_gear(input logic nsw, input logic [7:0] s);
		logic [2:0] g;
		g = GEAR_INVALID;
		if (!nsw) begin
			g = GEAR_NEUTRAL;
		end else if (s <= GEAR_WIN[0]) begin
			g = GEAR_FIRST;
		end else if (s >= GEAR_WIN[5] && {1'b0, s} <= {1'b0, GEAR_WIN[5]} + TOP_SPAN) begin
			g = GEAR_TOP;
		end else begin
			// first matching window wins, so scan downward
			for (int k = 4; k >= 1; k--) begin
				if (s >= GEAR_WIN[k-1] && s <= GEAR_WIN[k]) begin
					g = 3'(k + 1);
				end
			end
		end
		return g;
	endfunction

endpackage

// ===== sv/gearshift_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the gear shift sequencer: stream ports, config registers, pipeline.
// Depends on gss_pkg and gss_step.

// One input beat is one control tick and yields exactly one result beat. A beat is
// captured into an input register, and in the cycle it moves on the sequencer state
// (time since last servo move, settle lock, phase, servo pulse) is updated and the
// result is written into the output register. Throughput is one beat per clock while
// the master side keeps taking results; a beat passes the input register and then the
// result register on its way to the master side. Both stages advance together
// whenever the result register is empty or being drained; while a finished result
// waits, the input register takes one more beat and then holds the slave side off.
// Config registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no beat is in flight.

module gearshift_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] elapsed_ms, [8] up_request, [9] down_request, [10] neutral_switch,
	// [18:11] gear_sample, [23:19] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] gear_now, [18:3] servo_pulse, [19] servo_enable, [20] shift_busy,
	// [23:21] phase
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gss_pkg::cfg_t    cfg_q;
	gss_pkg::state_t  st_q;
	gss_pkg::state_t  st_nxt;
	gss_pkg::item_t   item_s1;
	logic             vld_s1;
	gss_pkg::result_t res_nxt;
	gss_pkg::result_t res_s2;
	logic             vld_s2;
	logic             adv;

	// move the held beat on when the result register is free or draining
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2;

	// config registers, write-only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_mid      <= gss_pkg::RST_PULSE_MID;
			cfg_q.pulse_up       <= gss_pkg::RST_PULSE_UP;
			cfg_q.pulse_down     <= gss_pkg::RST_PULSE_DOWN;
			cfg_q.pulse_neutral  <= gss_pkg::RST_PULSE_NEUTRAL;
			cfg_q.dead_time_ms   <= gss_pkg::RST_DEAD_TIME;
			cfg_q.hold_short_ms  <= gss_pkg::RST_HOLD_SHORT;
			cfg_q.hold_long_ms   <= gss_pkg::RST_HOLD_LONG;
			cfg_q.settle_lock_ms <= gss_pkg::RST_SETTLE_LOCK;
		end else if (cfg_we) begin
			case (cfg_index)
				gss_pkg::REG_PULSE_MID:     cfg_q.pulse_mid      <= cfg_data;
				gss_pkg::REG_PULSE_UP:      cfg_q.pulse_up       <= cfg_data;
				gss_pkg::REG_PULSE_DOWN:    cfg_q.pulse_down     <= cfg_data;
				gss_pkg::REG_PULSE_NEUTRAL: cfg_q.pulse_neutral  <= cfg_data;
				gss_pkg::REG_DEAD_TIME:     cfg_q.dead_time_ms   <= cfg_data;
				gss_pkg::REG_HOLD_SHORT:    cfg_q.hold_short_ms  <= cfg_data;
				gss_pkg::REG_HOLD_LONG:     cfg_q.hold_long_ms   <= cfg_data;
				gss_pkg::REG_SETTLE_LOCK:   cfg_q.settle_lock_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata;
		end
	end

	gss_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// sequencer state, advanced once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.since_move_ms <= 16'd0;
			st_q.settle_lock   <= 16'd0;
			st_q.busy_flag     <= 1'b0;
			st_q.seq_phase     <= gss_pkg::PH_IDLE;
			st_q.long_hold     <= 1'b0;
			st_q.pulse_reg     <= gss_pkg::RST_PULSE_MID;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// busy and a non-idle phase go together
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.busy_flag == (st_q.seq_phase != gss_pkg::PH_IDLE))
		else $error("busy flag and sequencer phase disagree");

	// a busy result always has the servo enabled
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.shift_busy) |-> res_s2.servo_enable)
		else $error("busy result without servo enable");

	// a stalled result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !m_tready) |-> !adv)
		else $error("result register overwritten while stalled");

	// the state only moves when a beat moves into the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("sequencer state changed without a beat");

endmodule

// ===== sv/gss_step.sv =====
`timescale 1ns / 1ps
// One control tick of the shift sequencer: timers, gear decode, next state and result.
// Purely combinational; depends on gss_pkg.

module gss_step (
	input  gss_pkg::cfg_t    cfg,
	input  gss_pkg::state_t  st,
	input  gss_pkg::item_t   item,
	output gss_pkg::state_t  st_nxt,
	output gss_pkg::result_t res
);

	logic [16:0] since_sum;
	logic [15:0] since_sat;
	logic [15:0] lock_dec;
	logic [15:0] el_ext;
	logic [2:0]  gear;
	logic [15:0] hold_lim;

	assign el_ext    = {8'd0, item.elapsed_ms};
	assign since_sum = {1'b0, st.since_move_ms} + {1'b0, el_ext};
	assign since_sat = since_sum[16] ? 16'hFFFF : since_sum[15:0];
	assign lock_dec  = (st.settle_lock > el_ext) ? (st.settle_lock - el_ext) : 16'd0;
	assign gear      = gss_pkg::decode_gear(item.neutral_switch, item.gear_sample);
	assign hold_lim  = st.long_hold ? cfg.hold_long_ms : cfg.hold_short_ms;

	// next state
	always_comb begin
		st_nxt               = st;
		st_nxt.since_move_ms = since_sat;
		st_nxt.settle_lock   = lock_dec;
		if (!st.busy_flag && since_sat > cfg.dead_time_ms) begin
			if (item.up_request && gear < gss_pkg::GEAR_TOP) begin
				st_nxt.busy_flag = 1'b1;
				if (gear == gss_pkg::GEAR_NEUTRAL) begin
					st_nxt.seq_phase = gss_pkg::PH_DOWN;
					st_nxt.long_hold = 1'b1;
				end else begin
					st_nxt.seq_phase = gss_pkg::PH_UP;
					st_nxt.long_hold = 1'b0;
				end
			end else if (item.down_request && gear != gss_pkg::GEAR_NEUTRAL) begin
				st_nxt.busy_flag = 1'b1;
				st_nxt.long_hold = 1'b1;
				st_nxt.seq_phase = (gear == gss_pkg::GEAR_FIRST) ? gss_pkg::PH_NEUTRAL
				                                                 : gss_pkg::PH_DOWN;
			end
		end else begin
			case (st.seq_phase)
				gss_pkg::PH_DOWN: begin
					st_nxt.pulse_reg     = cfg.pulse_down;
					st_nxt.since_move_ms = 16'd0;
					st_nxt.seq_phase     = gss_pkg::PH_HOLD;
				end
				gss_pkg::PH_UP: begin
					st_nxt.pulse_reg     = cfg.pulse_up;
					st_nxt.since_move_ms = 16'd0;
					st_nxt.seq_phase     = gss_pkg::PH_HOLD;
				end
				gss_pkg::PH_NEUTRAL: begin
					st_nxt.pulse_reg     = cfg.pulse_neutral;
					st_nxt.since_move_ms = 16'd0;
					st_nxt.seq_phase     = gss_pkg::PH_HOLD;
				end
				gss_pkg::PH_HOLD: begin
					if (since_sat >= hold_lim) begin
						st_nxt.seq_phase = gss_pkg::PH_RETURN;
					end
				end
				gss_pkg::PH_RETURN: begin
					st_nxt.pulse_reg     = cfg.pulse_mid;
					st_nxt.since_move_ms = 16'd0;
					st_nxt.settle_lock   = cfg.settle_lock_ms;
					st_nxt.busy_flag     = 1'b0;
					st_nxt.seq_phase     = gss_pkg::PH_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	// result
	always_comb begin
		res.gear_now     = gear;
		res.servo_pulse  = st_nxt.pulse_reg;
		res.servo_enable = (st_nxt.settle_lock != 16'd0) || st_nxt.busy_flag;
		res.shift_busy   = st_nxt.busy_flag;
		// the return step reports as holding
		res.phase        = (st_nxt.seq_phase == gss_pkg::PH_RETURN) ? 3'(gss_pkg::PH_HOLD)
		                                                           : 3'(st_nxt.seq_phase);
	end

endmodule

// ===== tb/gearshift_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gearshift_sequencer: streams control ticks with random gaps
// and back-pressure, predicts each result beat and compares it field by field.
// Depends on gss_pkg (beat, phase and register types) and the gearshift_sequencer RTL.

module gearshift_sequencer_tb;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	localparam int QUIET_LIMIT   = 2000;	// cycles with no beat moving before giving up
	localparam int SETTLE_CYCLES = 4;		// hold-off after the last result, two-stage pipe

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	gearshift_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shift sequencer prediction: own copy of the settings and state
	// ------------------------------------------------------------------
	logic [15:0]     cfg_model [8];
	logic [15:0]     since_move_ms;
	logic [15:0]     settle_count;
	logic            busy;
	logic            long_hold;
	gss_pkg::phase_t shift_phase;
	logic [15:0]     pulse_now;
	logic [2:0]      gear_model;

	gss_pkg::result_t pending_results [$];	// predicted result beats, oldest first

	int ticks_sent      = 0;
	int results_checked = 0;
	int shifts_started  = 0;
	int settings_loaded = 0;
	int fail_count      = 0;
	int quiet_cycles    = 0;

	// When set, the sender or the receiver runs without idle cycles.
	bit src_steady  = 1'b0;
	bit sink_steady = 1'b0;

	function automatic void reset_model();
		cfg_model[gss_pkg::REG_PULSE_MID]     = 16'd3100;
		cfg_model[gss_pkg::REG_PULSE_UP]      = 16'd1707;
		cfg_model[gss_pkg::REG_PULSE_DOWN]    = 16'd4292;
		cfg_model[gss_pkg::REG_PULSE_NEUTRAL] = 16'd2538;
		cfg_model[gss_pkg::REG_DEAD_TIME]     = 16'd500;
		cfg_model[gss_pkg::REG_HOLD_SHORT]    = 16'd200;
		cfg_model[gss_pkg::REG_HOLD_LONG]     = 16'd300;
		cfg_model[gss_pkg::REG_SETTLE_LOCK]   = 16'd180;
		since_move_ms = '0;
		settle_count  = '0;
		busy          = 1'b0;
		long_hold     = 1'b0;
		shift_phase   = gss_pkg::PH_IDLE;
		pulse_now     = 16'd3100;
		gear_model    = gss_pkg::GEAR_NEUTRAL;
	endfunction

	// Map the neutral switch and the sensor sample onto a gear. Windows share their
	// edges; the lower gear owns a shared edge, and 233..243 belongs to top gear.
	function automatic logic [2:0] gear_from_sensor(input logic nsw, input logic [7:0] smp);
		if (!nsw)
			return gss_pkg::GEAR_NEUTRAL;
		if (smp <= 8'd91)
			return gss_pkg::GEAR_FIRST;
		if (smp >= 8'd233 && smp <= 8'd243)
			return gss_pkg::GEAR_TOP;
		if (smp <= 8'd133)
			return 3'd2;
		if (smp <= 8'd166)
			return 3'd3;
		if (smp <= 8'd194)
			return 3'd4;
		if (smp <= 8'd220)
			return 3'd5;
		return gss_pkg::GEAR_INVALID;
	endfunction

	// Advance the predicted sequencer by one control tick and return its result beat.
	function automatic gss_pkg::result_t shift_tick(input gss_pkg::item_t tick);
		logic [16:0]      sum;
		gss_pkg::result_t res;
		// advance the time since the last move, saturating at the counter top
		sum = {1'b0, since_move_ms} + 17'(tick.elapsed_ms);
		since_move_ms = sum[16] ? 16'hFFFF : sum[15:0];
		// count the settle lock down, stopping at zero
		if (settle_count != 0)
			settle_count = (settle_count > 16'(tick.elapsed_ms)) ?
				settle_count - 16'(tick.elapsed_ms) : 16'd0;
		gear_model = gear_from_sensor(tick.neutral_switch, tick.gear_sample);

		if (!busy && since_move_ms > cfg_model[gss_pkg::REG_DEAD_TIME]) begin
			// up wins over down as long as there is a gear above
			if (tick.up_request && gear_model < gss_pkg::GEAR_TOP) begin
				busy = 1'b1;
				shifts_started++;
				if (gear_model == gss_pkg::GEAR_NEUTRAL) begin
					shift_phase = gss_pkg::PH_DOWN;
					long_hold   = 1'b1;
				end else begin
					shift_phase = gss_pkg::PH_UP;
					long_hold   = 1'b0;
				end
			end else if (tick.down_request && gear_model > gss_pkg::GEAR_NEUTRAL) begin
				busy = 1'b1;
				shifts_started++;
				long_hold   = 1'b1;
				shift_phase = (gear_model == gss_pkg::GEAR_FIRST) ? gss_pkg::PH_NEUTRAL
					: gss_pkg::PH_DOWN;
			end
		end else begin
			case (shift_phase)
				gss_pkg::PH_DOWN, gss_pkg::PH_UP, gss_pkg::PH_NEUTRAL: begin
					pulse_now = (shift_phase == gss_pkg::PH_DOWN) ?
						cfg_model[gss_pkg::REG_PULSE_DOWN] :
						(shift_phase == gss_pkg::PH_UP) ? cfg_model[gss_pkg::REG_PULSE_UP] :
						cfg_model[gss_pkg::REG_PULSE_NEUTRAL];
					since_move_ms = '0;
					shift_phase   = gss_pkg::PH_HOLD;
				end
				gss_pkg::PH_HOLD: begin
					if (since_move_ms >= (long_hold ? cfg_model[gss_pkg::REG_HOLD_LONG] :
						cfg_model[gss_pkg::REG_HOLD_SHORT]))
						shift_phase = gss_pkg::PH_RETURN;
				end
				gss_pkg::PH_RETURN: begin
					pulse_now     = cfg_model[gss_pkg::REG_PULSE_MID];
					since_move_ms = '0;
					settle_count  = cfg_model[gss_pkg::REG_SETTLE_LOCK];
					busy          = 1'b0;
					shift_phase   = gss_pkg::PH_IDLE;
				end
				default: begin
				end
			endcase
		end

		res.gear_now     = gear_model;
		res.servo_pulse  = pulse_now;
		res.servo_enable = (settle_count != 0) || busy;
		res.shift_busy   = busy;
		// the return-to-mid step is reported as holding
		res.phase        = (shift_phase == gss_pkg::PH_RETURN) ? gss_pkg::PH_HOLD : shift_phase;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stream driving
	// ------------------------------------------------------------------

	// Send one control tick: idle a random number of cycles, then hold the beat until
	// the slave side takes it. Keep tvalid high between back-to-back beats.
	task automatic send_tick(input logic [7:0] el, input logic up, input logic dn,
		input logic nsw, input logic [7:0] smp);
		gss_pkg::item_t tick;
		int             gap;
		tick                = '0;
		tick.elapsed_ms     = el;
		tick.up_request     = up;
		tick.down_request   = dn;
		tick.neutral_switch = nsw;
		tick.gear_sample    = smp;
		gap = src_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= tick;
		s_tvalid <= 1'b1;
		pending_results.push_back(shift_tick(tick));
		ticks_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop tvalid and wait until every predicted result has come back, then let the
	// pipeline settle before anything touches the settings.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all eight registers, one per cycle, and mirror them in the prediction.
	task automatic apply_settings(input logic [15:0] mid, input logic [15:0] up_w,
		input logic [15:0] down_w, input logic [15:0] neutral_w, input logic [15:0] dead,
		input logic [15:0] hold_s, input logic [15:0] hold_l, input logic [15:0] settle);
		logic [15:0] vals [8];
		vals[gss_pkg::REG_PULSE_MID]     = mid;
		vals[gss_pkg::REG_PULSE_UP]      = up_w;
		vals[gss_pkg::REG_PULSE_DOWN]    = down_w;
		vals[gss_pkg::REG_PULSE_NEUTRAL] = neutral_w;
		vals[gss_pkg::REG_DEAD_TIME]     = dead;
		vals[gss_pkg::REG_HOLD_SHORT]    = hold_s;
		vals[gss_pkg::REG_HOLD_LONG]     = hold_l;
		vals[gss_pkg::REG_SETTLE_LOCK]   = settle;
		for (int i = 0; i < 8; i++) begin
			cfg_we       <= 1'b1;
			cfg_index    <= gss_pkg::reg_idx_t'(i);
			cfg_data     <= vals[i];
			cfg_model[i]  = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Random ticks shaped like a driver on track: the gear sensor mostly sits in one
	// window and moves now and then, paddles are pressed at random, and a fifth of the
	// samples are raw noise. Toggle steady stretches on either side every 40 ticks.
	task automatic random_ticks(input int count, input int el_max);
		logic [7:0] el;
		logic [7:0] smp;
		logic       nsw;
		int         held_gear;
		held_gear = $urandom_range(1, 6);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				src_steady  = ($urandom_range(0, 3) == 0);
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 7) == 0)
				held_gear = $urandom_range(1, 6);
			el = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, el_max));
			nsw = ($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 4) == 0) begin
				smp = 8'($urandom);
			end else begin
				case (held_gear)
					1: smp = 8'($urandom_range(0, 91));
					2: smp = 8'($urandom_range(92, 133));
					3: smp = 8'($urandom_range(134, 166));
					4: smp = 8'($urandom_range(167, 194));
					5: smp = 8'($urandom_range(195, 220));
					default: smp = 8'($urandom_range(233, 243));
				endcase
			end
			send_tick(el, ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0), nsw, smp);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Check the reset outputs, then run every kind of shift back to back with a zero
	// dead time and one-tick holds. The ticks inside each shift sweep the sensor
	// across every window edge while the neutral switch toggles, and the last shift starts
	// with a full elapsed value so the settle lock has to stop at zero.
	task automatic test_directed_shifts();
		logic [7:0] edge_samples [18] = '{8'd91, 8'd92, 8'd133, 8'd134, 8'd166, 8'd167,
			8'd194, 8'd195, 8'd220, 8'd221, 8'd232, 8'd233, 8'd243, 8'd244, 8'd255,
			8'd0, 8'hAA, 8'h55};
		// per shift: up, down, neutral switch, sample at the start tick
		logic       start_up  [6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
		logic       start_dn  [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		logic       start_nsw [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		logic [7:0] start_smp [6] = '{8'h55, 8'd150, 8'd0, 8'd200, 8'd250, 8'd240};
		int         k;
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		// an early paddle at reset timing must be refused
		send_tick(8'd0, 1'b1, 1'b1, 1'b1, 8'd120);
		drain_results();
		apply_settings(16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd0, 16'd1, 16'd1, 16'd3);
		k = 0;
		for (int s = 0; s < 6; s++) begin
			send_tick((s == 5) ? 8'd255 : 8'd1, start_up[s], start_dn[s], start_nsw[s],
				start_smp[s]);
			for (int j = 0; j < 3; j++) begin
				// paddles pressed mid-shift are ignored; the return tick carries no time
				send_tick((j == 2) ? 8'd0 : 8'd1, 1'b1, 1'b1, k[0], edge_samples[k]);
				k++;
			end
		end
	endtask

	task automatic test_reset_timing();
		drain_results();
		apply_settings(16'd3100, 16'd1707, 16'd4292, 16'd2538, 16'd500, 16'd200, 16'd300,
			16'd180);
		random_ticks(500, 60);
	endtask

	// All zero: a shift starts on any tick with time elapsed, holds end at once.
	task automatic test_zero_settings();
		drain_results();
		apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
		random_ticks(200, 3);
	endtask

	// All ones: the time since the last move saturates and never passes the dead time.
	task automatic test_max_settings();
		drain_results();
		apply_settings('1, '1, '1, '1, '1, '1, '1, '1);
		random_ticks(150, 255);
	endtask

	// Holds that only end once the time counter saturates, and a long settle lock.
	task automatic test_saturated_hold();
		drain_results();
		apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd20,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_ticks(350, 255);
	endtask

	task automatic test_random_settings();
		for (int r = 0; r < 4; r++) begin
			drain_results();
			apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
				16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
			random_ticks(160, $urandom_range(5, 120));
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking: stall the master side at random and compare each beat
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin : result_checker
		gss_pkg::result_t got;
		gss_pkg::result_t want;
		int               stall;
		@(posedge arst_n);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result beat %h arrived with no tick outstanding", got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("gear_now", want.gear_now, got.gear_now);
				check_field("servo_pulse", want.servo_pulse, got.servo_pulse);
				check_field("servo_enable", want.servo_enable, got.servo_enable);
				check_field("shift_busy", want.shift_busy, got.shift_busy);
				check_field("phase", want.phase, got.phase);
				results_checked++;
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, pending_results.size());
			$display("FAIL gearshift_sequencer");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_shifts();
		test_reset_timing();
		test_zero_settings();
		test_max_settings();
		test_saturated_hold();
		test_random_settings();

		drain_results();
		$display("Ran %0d control ticks through %0d register settings, %0d shifts started,",
			ticks_sent, settings_loaded, shifts_started);
		$display("%0d result beats compared with %0d field mismatches.",
			results_checked, fail_count);
		if (fail_count == 0) begin
			$display("PASS gearshift_sequencer");
		end else begin
			$display("FAIL gearshift_sequencer");
		end
		$finish;
	end

endmodule
